### sv/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg
// shared types and constants for the latency percentile statistics block
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int MaxSamples = 1024;
  localparam int IdxW = $clog2(MaxSamples);
  localparam int CntW = IdxW + 1;
  localparam int SumW = 32 + CntW;
  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);
  localparam int CntQ = QPtrW + 1;
  localparam logic [31:0] NoResult = 32'd10000;

  // rank = (n-1)*9/10 and (n-1)*99/100 as one reciprocal multiply and shift,
  // exact for every count up to MaxSamples
  localparam int Rank90Shift = 19;
  localparam int Rank90Mul = 9 * 52429;
  localparam int Rank99Shift = 24;
  localparam int Rank99Mul = 99 * 167773;

  typedef struct packed {
    logic        keep;
    logic [31:0] rtt;
    logic        last;
  } lps_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INS,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_RANK,
    ST_RD90,
    ST_RD99,
    ST_DIV,
    ST_OUT
  } lps_state_t;

endpackage

### sv/lps_front.sv
// ----------------------------------------------------------------------------
// lps_front
// accepts sample beats, classifies them and queues commands for the back end
// ----------------------------------------------------------------------------
module lps_front import lps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_rx_packets,
  input  logic [31:0] in_round_trip_time,
  input  logic        in_target_end,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output lps_cmd_t    cmd
);

  lps_cmd_t          q_r [QDepth];
  logic [QPtrW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QPtrW:0]    cnt_r, cnt_nxt;
  logic              push, pop;

  assign in_ready  = (cnt_r != CntQ'(QDepth));
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt_r != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + CntQ'(push) - CntQ'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{keep: (in_rx_packets != '0), rtt: in_round_trip_time,
                     last: in_target_end};
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntQ'(QDepth)) else $error("queue count beyond depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CntQ'(QDepth) |-> !push) else $error("push into full queue");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1) else $error("count drift");

endmodule

### sv/lps_back.sv
// ----------------------------------------------------------------------------
// lps_back
// sorted insertion into the sample memory, rank select and mean divide
// ----------------------------------------------------------------------------
module lps_back import lps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  lps_cmd_t    cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_p90_latency,
  output logic [31:0] out_p99_latency,
  output logic [31:0] out_mean_latency,
  output logic [10:0] out_valid_count,
  output logic        out_overflowed
);

  logic [31:0]     mem [MaxSamples];
  logic [31:0]     rd_data_r;
  logic [IdxW-1:0] rd_addr, wr_addr;
  logic [31:0]     wr_data;
  logic            wr_en;

  lps_state_t      st_r, st_nxt;
  lps_cmd_t        c_r;
  logic [CntW-1:0] n_r, n_nxt, i_r, i_nxt;
  logic [SumW-1:0] sum_r, sum_nxt;
  logic            ovf_r, ovf_nxt;
  logic [CntW-1:0] r90_r, r99_r;
  logic [IdxW-1:0] nm1;
  logic [IdxW+Rank90Shift-1:0] top9;
  logic [IdxW+Rank99Shift-1:0] top99;
  logic [31:0]     p90_r, p99_r;
  logic [SumW-1:0] rem_r;
  logic [31:0]     quo_r;
  logic [5:0]      dcnt_r;
  logic [CntW+1:0] trial;
  logic            ovalid_r;
  logic [31:0]     o90_r, o99_r, omean_r;
  logic [10:0]     ocnt_r;
  logic            oovf_r;

  // memory: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  assign cmd_ready = (st_r == ST_IDLE);
  assign nm1   = IdxW'(n_r - 1'b1);
  assign top9  = (IdxW+Rank90Shift)'(nm1) * (IdxW+Rank90Shift)'(Rank90Mul);
  assign top99 = (IdxW+Rank99Shift)'(nm1) * (IdxW+Rank99Shift)'(Rank99Mul);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.keep && n_r != CntW'(MaxSamples)) st_nxt = ST_SCAN;
          else if (cmd.last) st_nxt = ST_RANK;
        end
      end
      ST_SCAN:     st_nxt = ST_INS;
      ST_INS:      st_nxt = (i_r == '0 || rd_data_r <= c_r.rtt) ? ST_SHIFT_WR : ST_SHIFT_RD;
      ST_SHIFT_RD: st_nxt = ST_INS;
      ST_SHIFT_WR: st_nxt = c_r.last ? ST_RANK : ST_IDLE;
      ST_RANK:     st_nxt = (n_r == '0) ? ST_OUT : ST_RD90;
      ST_RD90:     st_nxt = ST_RD99;
      ST_RD99:     st_nxt = ST_DIV;
      ST_DIV:      st_nxt = (dcnt_r == '0) ? ST_OUT : ST_DIV;
      ST_OUT:      st_nxt = (!ovalid_r || out_ready) ? ST_IDLE : ST_OUT;
      default:     st_nxt = ST_IDLE;
    endcase
  end

  // insertion walks down from the top; i_r is the free slot
  always_comb begin
    rd_addr = i_r[IdxW-1:0] - 1'b1;
    wr_en   = 1'b0;
    wr_addr = i_r[IdxW-1:0];
    wr_data = c_r.rtt;
    case (st_r)
      ST_IDLE:     rd_addr = n_r[IdxW-1:0] - 1'b1;
      ST_INS: begin
        if (i_r != '0 && rd_data_r > c_r.rtt) begin
          wr_en   = 1'b1;
          wr_data = rd_data_r;
        end
      end
      ST_SHIFT_RD: rd_addr = i_r[IdxW-1:0] - 1'b1;
      ST_SHIFT_WR: wr_en = 1'b1;
      ST_RD90:     rd_addr = r90_r[IdxW-1:0];
      ST_RD99:     rd_addr = r99_r[IdxW-1:0];
      default:     wr_en = 1'b0;
    endcase
  end

  always_comb begin
    n_nxt   = n_r;
    i_nxt   = i_r;
    sum_nxt = sum_r;
    ovf_nxt = ovf_r;
    case (st_r)
      ST_IDLE: begin
        i_nxt = n_r;
        if (cmd_valid && cmd.keep) begin
          if (n_r != CntW'(MaxSamples)) sum_nxt = sum_r + SumW'(cmd.rtt);
          else ovf_nxt = 1'b1;
        end
      end
      ST_INS: if (i_r != '0 && rd_data_r > c_r.rtt) i_nxt = i_r - 1'b1;
      ST_SHIFT_WR: n_nxt = n_r + 1'b1;
      ST_OUT: begin
        if (!ovalid_r || out_ready) begin
          n_nxt   = '0;
          sum_nxt = '0;
          ovf_nxt = 1'b0;
        end
      end
      default: n_nxt = n_r;
    endcase
  end

  // partial remainder with the next dividend bit shifted in, less the count
  assign trial = (CntW+2)'(rem_r[SumW-1:31]) - (CntW+2)'(n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      n_r      <= '0;
      sum_r    <= '0;
      ovf_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      n_r   <= n_nxt;
      sum_r <= sum_nxt;
      ovf_r <= ovf_nxt;
      if (st_r == ST_OUT && (!ovalid_r || out_ready)) ovalid_r <= 1'b1;
      else if (ovalid_r && out_ready) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    if (st_r == ST_IDLE && cmd_valid) c_r <= cmd;
    if (st_r == ST_RANK) begin
      r90_r  <= CntW'(top9[IdxW+Rank90Shift-1:Rank90Shift]);
      r99_r  <= CntW'(top99[IdxW+Rank99Shift-1:Rank99Shift]);
      rem_r  <= sum_r;
      quo_r  <= '0;
      dcnt_r <= 6'd32;
    end
    if (st_r == ST_RD99) p90_r <= rd_data_r;
    if (st_r == ST_DIV) begin
      if (dcnt_r == 6'd32) p99_r <= rd_data_r;
      if (dcnt_r != '0) begin
        // restoring divide, one quotient bit a cycle
        if (!trial[CntW+1]) begin
          rem_r <= {trial[CntW-1:0], rem_r[30:0], 1'b0};
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= {rem_r[SumW-2:0], 1'b0};
          quo_r <= {quo_r[30:0], 1'b0};
        end
        dcnt_r <= dcnt_r - 1'b1;
      end
    end
    if (st_r == ST_OUT && (!ovalid_r || out_ready)) begin
      o90_r   <= (n_r == '0) ? NoResult : p90_r;
      o99_r   <= (n_r == '0) ? NoResult : p99_r;
      omean_r <= (n_r == '0) ? NoResult : quo_r;
      ocnt_r  <= 11'(n_r);
      oovf_r  <= ovf_r;
    end
  end

  assign out_valid        = ovalid_r;
  assign out_p90_latency  = o90_r;
  assign out_p99_latency  = o99_r;
  assign out_mean_latency = omean_r;
  assign out_valid_count  = ocnt_r;
  assign out_overflowed   = oovf_r;

  a_n_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CntW'(MaxSamples)) else $error("sample count beyond capacity");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result beat dropped");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_OUT && st_nxt == ST_IDLE |=> n_r == '0 && !ovf_r)
    else $error("per-target state not cleared");

endmodule

### sv/latency_percentile_stats.sv
// ----------------------------------------------------------------------------
// latency_percentile_stats
// p90, p99 and mean of round-trip times over the ping samples of one target
// ----------------------------------------------------------------------------
// input beats carry one ping sample; a sample with nonzero rx_packets is kept
// and inserted in sorted order into a 1024-entry memory. the front end queues
// classified samples so the sender keeps going while the back end works.
// a kept sample is put in place walking down from the top, each stored entry
// larger than it moved up one slot by a memory read and a write; the back end
// takes no new command until that is done. the beat with target_end set yields
// one result beat after any insertion, a rank compute, two memory reads and
// a restoring mean divide. with no kept sample the latencies read 10000.
// reset clears counters, sum and handshake state; the memory needs no clear.
// while the receiver stalls the result is held; the back end runs on until its
// next result, then stops, and the queue fills before in_ready drops.
module latency_percentile_stats import lps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_rx_packets,
  input  logic [31:0] in_round_trip_time,
  input  logic        in_target_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_p90_latency,
  output logic [31:0] out_p99_latency,
  output logic [31:0] out_mean_latency,
  output logic [10:0] out_valid_count,
  output logic        out_overflowed
);

  logic     cmd_valid, cmd_ready;
  lps_cmd_t cmd;

  lps_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_rx_packets, .in_round_trip_time,
    .in_target_end, .cmd_valid, .cmd_ready, .cmd
  );

  lps_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd, .out_valid, .out_ready,
    .out_p90_latency, .out_p99_latency, .out_mean_latency, .out_valid_count,
    .out_overflowed
  );

endmodule
